// ===== design/lbfl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbfl_pkg
// shared types, constants and the sequencer program of the buffer free list
// ----------------------------------------------------------------------------
package lbfl_pkg;

    localparam int POOL_SIZE = 256;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = IDX_W + 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int LEN_W     = 9;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_SIZE);

    typedef enum logic [1:0] {
        FN_TAKE_ONE = 2'd0,
        FN_TAKE_RUN = 2'd1,
        FN_RET_ONE  = 2'd2,
        FN_RET_RUN  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        UP_IDLE  = 3'd0,
        UP_CHECK = 3'd1,
        UP_READ  = 3'd2,
        UP_WALK  = 3'd3,
        UP_PUSH  = 3'd4,
        UP_EMIT  = 3'd5
    } upc_t;

    typedef enum logic [2:0] {
        J_ALWAYS   = 3'd0,
        J_ACCEPT   = 3'd1,
        J_DISPATCH = 3'd2,
        J_WALK     = 3'd3,
        J_OUTFREE  = 3'd4
    } jump_t;

    typedef struct packed {
        logic  latch;
        logic  check;
        logic  rd;
        logic  walk;
        logic  push;
        logic  emit;
        jump_t jump;
        upc_t  target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic refuse;
        logic is_take;
        logic walk_last;
        logic out_free;
    } seq_cond_t;

    function automatic ucode_t ucode_rom(input upc_t step);
        ucode_t w;
        w = '{latch: 1'b0, check: 1'b0, rd: 1'b0, walk: 1'b0, push: 1'b0,
              emit: 1'b0, jump: J_ALWAYS, target: UP_IDLE};
        unique case (step)
            UP_IDLE:
            begin
                w.latch  = 1'b1;
                w.jump   = J_ACCEPT;
                w.target = UP_CHECK;
            end
            UP_CHECK:
            begin
                w.check  = 1'b1;
                w.jump   = J_DISPATCH;
                w.target = UP_READ;
            end
            UP_READ:
            begin
                w.rd     = 1'b1;
                w.jump   = J_ALWAYS;
                w.target = UP_WALK;
            end
            UP_WALK:
            begin
                w.walk   = 1'b1;
                w.jump   = J_WALK;
                w.target = UP_EMIT;
            end
            UP_PUSH:
            begin
                w.push   = 1'b1;
                w.jump   = J_ALWAYS;
                w.target = UP_EMIT;
            end
            UP_EMIT:
            begin
                w.emit   = 1'b1;
                w.jump   = J_OUTFREE;
                w.target = UP_IDLE;
            end
        endcase
        return w;
    endfunction

    // link held by an entry that was never written
    function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] addr);
        logic [LINK_W-1:0] v;
        if (addr == '0)
        begin
            v = NIL_LINK;
        end
        else
        begin
            v = {1'b0, addr - IDX_W'(1)};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/lbfl_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbfl_req_if / lbfl_rsp_if
// request and response channels of the buffer free list
// ----------------------------------------------------------------------------
interface lbfl_req_if;
    import lbfl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [IDX_W-1:0]     buffer_index;
    logic [IDX_W-1:0]     tail_index;
    logic [LEN_W-1:0]     run_length;

    modport source (output valid, output func, output buffer_index,
                    output tail_index, output run_length, input ready);
    modport sink   (input valid, input func, input buffer_index,
                    input tail_index, input run_length, output ready);
endinterface

interface lbfl_rsp_if;
    import lbfl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     granted_index;
    logic [1:0]           status;
    logic [CNT_W-1:0]     free_left;

    modport source (output valid, output granted_index, output status,
                    output free_left, input ready);
    modport sink   (input valid, input granted_index, input status,
                    input free_left, output ready);
endinterface
`default_nettype wire

// ===== design/lbfl_link_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbfl_link_mem
// link memory, one write and one registered read port, with per-entry
// valid bits so that unwritten entries read as their reset link
// ----------------------------------------------------------------------------
module lbfl_link_mem (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [lbfl_pkg::IDX_W-1:0]    rd_addr,
    output logic      [lbfl_pkg::LINK_W-1:0]   rd_data,
    input  wire logic                          wr_en,
    input  wire logic [lbfl_pkg::IDX_W-1:0]    wr_addr,
    input  wire logic [lbfl_pkg::LINK_W-1:0]   wr_data
);
    import lbfl_pkg::*;

    logic [LINK_W-1:0]    mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] valid_reg;
    logic [LINK_W-1:0]    rd_word_reg;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic                 rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : reset_link(rd_addr_reg);

endmodule
`default_nettype wire

// ===== design/lbfl_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbfl_seq
// step counter and program table; issues one control word per step
// ----------------------------------------------------------------------------
module lbfl_seq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lbfl_pkg::seq_cond_t   cond,
    output lbfl_pkg::ucode_t           ctl
);
    import lbfl_pkg::*;

    upc_t step_reg;
    upc_t step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= UP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        unique case (ctl.jump)
            J_ALWAYS:
            begin
                step_next = ctl.target;
            end
            J_ACCEPT:
            begin
                if (cond.in_valid)
                begin
                    step_next = ctl.target;
                end
            end
            J_DISPATCH:
            begin
                if (cond.refuse)
                begin
                    step_next = UP_EMIT;
                end
                else if (cond.is_take)
                begin
                    step_next = ctl.target;
                end
                else
                begin
                    step_next = UP_PUSH;
                end
            end
            J_WALK:
            begin
                step_next = cond.walk_last ? ctl.target : UP_READ;
            end
            J_OUTFREE:
            begin
                if (cond.out_free)
                begin
                    step_next = ctl.target;
                end
            end
            default:
            begin
                step_next = UP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = ucode_rom(step_reg);
    end

endmodule
`default_nettype wire

// ===== design/linked_buffer_free_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linked_buffer_free_list
// pool of 256 buffers kept as a lifo linked free list
//
// req carries one operation per beat: take one, take a run of run_length,
// return one buffer_index, or return a run from buffer_index to tail_index.
// rsp carries one beat per request: granted_index, status and free_left.
// one request is worked at a time; req.ready is high only while the
// sequencer waits at its idle step, and a finished beat held in the output
// register does not stop the next request from being taken.
// refusals go from the check step straight to emit, returns go through
// the push step, and takes loop over the read and walk steps, one link
// read per step of the walk through the single read port of the link
// memory; the sequencer is back at its idle step before the next request.
// reset: list holds every buffer, head 255, each entry linking to the one
// below; links come from valid bits so no clearing pass is needed.
// a stalled rsp holds its beat; the sequencer waits at the emit step only
// if a new beat is ready while the previous one is still not taken.
// ----------------------------------------------------------------------------
module linked_buffer_free_list (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbfl_req_if.sink   req,
    lbfl_rsp_if.source rsp
);
    import lbfl_pkg::*;

    ucode_t             ctl;
    seq_cond_t          cond;

    func_t              func_reg;
    logic [IDX_W-1:0]   bidx_reg;
    logic [IDX_W-1:0]   tidx_reg;
    logic [LEN_W-1:0]   n_reg;
    logic [LINK_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [LEN_W-1:0]   iter_reg;
    status_t            status_reg;
    logic [IDX_W-1:0]   granted_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_granted_reg;
    logic [1:0]         out_status_reg;
    logic [CNT_W-1:0]   out_free_reg;

    logic               in_accept;
    logic               out_free;
    logic               is_take;
    logic               bad_len;
    logic               take_short;
    logic               ret_bad;
    logic [CNT_W:0]     ret_sum;
    status_t            check_status;
    logic [LINK_W-1:0]  rd_link;
    logic               walk_last;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [LINK_W-1:0]  mem_wr_data;

    assign req.ready = ctl.latch;
    assign in_accept = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // operation checks
    assign is_take    = (func_reg == FN_TAKE_ONE) || (func_reg == FN_TAKE_RUN);
    assign bad_len    = (n_reg == '0);
    assign ret_sum    = {1'b0, count_reg} + (CNT_W + 1)'(n_reg);
    assign take_short = (CNT_W'(count_reg) < CNT_W'(n_reg)) || (head_reg >= NIL_LINK);
    assign ret_bad    = bad_len
                     || ({1'b0, bidx_reg} >= CNT_W'(POOL_SIZE))
                     || ((func_reg == FN_RET_RUN) && ({1'b0, tidx_reg} >= CNT_W'(POOL_SIZE)))
                     || (ret_sum > (CNT_W + 1)'(POOL_SIZE));

    always_comb
    begin
        if (is_take)
        begin
            check_status = bad_len ? ST_BAD : (take_short ? ST_SHORT : ST_OK);
        end
        else
        begin
            check_status = ret_bad ? ST_BAD : ST_OK;
        end
    end

    assign walk_last = (iter_reg == '0) || (rd_link >= NIL_LINK);

    assign cond = '{in_valid:  req.valid,
                    refuse:    (check_status != ST_OK),
                    is_take:   is_take,
                    walk_last: walk_last,
                    out_free:  out_free};

    lbfl_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctl   (ctl)
    );

    // link memory writes: cut at end of a run walk, or splice on a return
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = cur_reg;
        mem_wr_data = NIL_LINK;
        if (ctl.push)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = (func_reg == FN_RET_RUN) ? tidx_reg : bidx_reg;
            mem_wr_data = head_reg;
        end
        else if (ctl.walk && walk_last && (func_reg == FN_TAKE_RUN))
        begin
            mem_wr_en = 1'b1;
        end
    end

    lbfl_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ctl.rd),
        .rd_addr (cur_reg),
        .rd_data (rd_link),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // request latch and walk registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func_t'(req.func);
            bidx_reg <= req.buffer_index;
            tidx_reg <= req.tail_index;
            if ((func_t'(req.func) == FN_TAKE_ONE) || (func_t'(req.func) == FN_RET_ONE))
            begin
                n_reg <= LEN_W'(1);
            end
            else
            begin
                n_reg <= req.run_length;
            end
        end
        if (ctl.check)
        begin
            status_reg  <= check_status;
            granted_reg <= (is_take && (check_status == ST_OK)) ? head_reg[IDX_W-1:0] : '0;
            cur_reg     <= head_reg[IDX_W-1:0];
            iter_reg    <= n_reg - LEN_W'(1);
        end
        if (ctl.walk && !walk_last)
        begin
            cur_reg  <= rd_link[IDX_W-1:0];
            iter_reg <= iter_reg - LEN_W'(1);
        end
    end

    // list head and free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= LINK_W'(POOL_SIZE - 1);
            count_reg <= CNT_W'(POOL_SIZE);
        end
        else if (ctl.walk && walk_last)
        begin
            head_reg  <= rd_link;
            count_reg <= count_reg - CNT_W'(n_reg);
        end
        else if (ctl.push)
        begin
            head_reg  <= {1'b0, bidx_reg};
            count_reg <= count_reg + CNT_W'(n_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit && out_free)
        begin
            out_granted_reg <= granted_reg;
            out_status_reg  <= status_reg;
            out_free_reg    <= count_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_granted_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.free_left     = out_free_reg;

endmodule
`default_nettype wire

// ===== design/lbfl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbfl_checker
// port-level checks on the buffer free list, bound to the top level
// ----------------------------------------------------------------------------
module lbfl_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_ready,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [lbfl_pkg::IDX_W-1:0]    rsp_granted_index,
    input  wire logic [1:0]                    rsp_status,
    input  wire logic [lbfl_pkg::CNT_W-1:0]    rsp_free_left
);
    import lbfl_pkg::*;

    // a stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_index)
            && $stable(rsp_status) && $stable(rsp_free_left))
    else $error("response beat changed while stalled");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is being worked");

    // refused beats grant nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != 2'(ST_OK)) |-> (rsp_granted_index == '0))
    else $error("refused beat carries a granted buffer");

    // free count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_free_left <= CNT_W'(POOL_SIZE)))
    else $error("free count above pool size");

endmodule

bind linked_buffer_free_list lbfl_checker u_lbfl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_granted_index (rsp.granted_index),
    .rsp_status        (rsp.status),
    .rsp_free_left     (rsp.free_left)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the linked buffer free list
//
// a queue of operations feeds a clocked driver on the request channel; each
// accepted beat runs through a local copy of the free list (head, count and
// link table), which gives the response expected back. a clocked monitor
// takes response beats under random back-pressure and compares them in
// order. a short directed opening covers the refusals, the empty pool, the
// short chain and a list whose head is null while buffers remain counted;
// the random part mostly takes buffers and gives back the runs it holds,
// with a little noise that can corrupt the list on purpose.
// ----------------------------------------------------------------------------
module testbench;
    import lbfl_pkg::*;

    typedef struct packed {
        func_t            func;
        logic [IDX_W-1:0] buffer_index;
        logic [IDX_W-1:0] tail_index;
        logic [LEN_W-1:0] run_length;
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        status_t          status;
        logic [CNT_W-1:0] free_left;
    } grant_t;

    typedef struct packed {
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
        logic [LEN_W-1:0] length;
    } run_t;

    logic clk;
    logic rst_n;

    lbfl_req_if req ();
    lbfl_rsp_if rsp ();

    linked_buffer_free_list i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    op_t    op_backlog[$];
    grant_t grant_fifo[$];
    run_t   held_runs[$];

    logic [LINK_W-1:0] link_mem [POOL_SIZE];
    logic [LINK_W-1:0] head_ptr;
    int                free_cnt;

    op_t              live_op;
    grant_t           next_grant;
    grant_t           want;
    logic [IDX_W-1:0] run_last;

    int errors;
    int beats_seen;
    int sent_cnt;
    int send_gap;
    int recv_gap;
    int hold_left;
    int hold_asks;
    int hold_taken;
    int longest_take;
    int st_hits [3];
    bit steady;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void pool_reset();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            link_mem[i] = (i == 0) ? NIL_LINK : LINK_W'(i - 1);
        end
        head_ptr = LINK_W'(POOL_SIZE - 1);
        free_cnt = POOL_SIZE;
    endfunction

    function automatic grant_t free_list_step(input op_t op, output logic [IDX_W-1:0] last);
        grant_t            g;
        logic [LINK_W-1:0] cur;
        int                n;
        g = '{granted_index: '0, status: ST_OK, free_left: '0};
        n = int'(op.run_length);
        cur = head_ptr;
        last = '0;
        case (op.func)
            FN_TAKE_ONE:
            begin
                if (free_cnt == 0 || head_ptr >= NIL_LINK)
                begin
                    g.status = ST_SHORT;
                end
                else
                begin
                    g.granted_index = head_ptr[IDX_W-1:0];
                    last = head_ptr[IDX_W-1:0];
                    head_ptr = link_mem[head_ptr[IDX_W-1:0]];
                    free_cnt--;
                end
            end
            FN_TAKE_RUN:
            begin
                if (n == 0)
                begin
                    g.status = ST_BAD;
                end
                else if (free_cnt < n || head_ptr >= NIL_LINK)
                begin
                    g.status = ST_SHORT;
                end
                else
                begin
                    g.granted_index = head_ptr[IDX_W-1:0];
                    // walk stops early on a null link
                    for (int i = 1; i < n; i++)
                    begin
                        if (link_mem[cur[IDX_W-1:0]] >= NIL_LINK)
                        begin
                            break;
                        end
                        cur = link_mem[cur[IDX_W-1:0]];
                    end
                    head_ptr = link_mem[cur[IDX_W-1:0]];
                    link_mem[cur[IDX_W-1:0]] = NIL_LINK;
                    free_cnt -= n;
                    last = cur[IDX_W-1:0];
                end
            end
            FN_RET_ONE:
            begin
                if (free_cnt >= POOL_SIZE)
                begin
                    g.status = ST_BAD;
                end
                else
                begin
                    link_mem[op.buffer_index] = head_ptr;
                    head_ptr = {1'b0, op.buffer_index};
                    free_cnt++;
                end
            end
            default:
            begin
                if (n == 0 || free_cnt + n > POOL_SIZE)
                begin
                    g.status = ST_BAD;
                end
                else
                begin
                    link_mem[op.tail_index] = head_ptr;
                    head_ptr = {1'b0, op.buffer_index};
                    free_cnt += n;
                end
            end
        endcase
        g.free_left = CNT_W'(free_cnt);
        return g;
    endfunction

    function automatic op_t make_op(input func_t f, input int b, input int t, input int n);
        op_t op;
        op.func         = f;
        op.buffer_index = IDX_W'(b);
        op.tail_index   = IDX_W'(t);
        op.run_length   = LEN_W'(n);
        return op;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // mostly takes and give-backs of held runs, a little raw noise
    function automatic op_t next_random_op();
        int   r;
        int   k;
        run_t h;
        op_t  op;
        r = $urandom_range(0, 99);
        op = make_op(FN_TAKE_ONE, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 511));
        if (r < 4)
        begin
            op.func = func_t'($urandom_range(0, 3));
        end
        else if (r < 52 || held_runs.size() == 0)
        begin
            k = $urandom_range(0, 99);
            if (k < 55)
            begin
                op.func = FN_TAKE_ONE;
            end
            else
            begin
                op.func = FN_TAKE_RUN;
                if (k < 92)
                begin
                    op.run_length = LEN_W'($urandom_range(1, 8));
                end
                else if (k < 99)
                begin
                    op.run_length = LEN_W'($urandom_range(9, 40));
                end
                else
                begin
                    op.run_length = LEN_W'($urandom_range(41, 256));
                end
            end
        end
        else
        begin
            k = $urandom_range(0, held_runs.size() - 1);
            h = held_runs[k];
            held_runs.delete(k);
            op.func = (h.length == 1 && $urandom_range(0, 1) == 1) ? FN_RET_ONE : FN_RET_RUN;
            op.buffer_index = h.head;
            op.tail_index   = h.tail;
            op.run_length   = h.length;
        end
        return op;
    endfunction

    task automatic wait_accepted();
        while (op_backlog.size() != 0 || req.valid)
        begin
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        wait_accepted();
        while (grant_fifo.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid        <= 1'b0;
            req.func         <= FN_TAKE_ONE;
            req.buffer_index <= '0;
            req.tail_index   <= '0;
            req.run_length   <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                next_grant = free_list_step(live_op, run_last);
                grant_fifo.push_back(next_grant);
                sent_cnt++;
                if (next_grant.status == ST_OK && live_op.func == FN_TAKE_ONE)
                begin
                    held_runs.push_back('{head: next_grant.granted_index, tail: run_last,
                                          length: LEN_W'(1)});
                end
                else if (next_grant.status == ST_OK && live_op.func == FN_TAKE_RUN)
                begin
                    held_runs.push_back('{head: next_grant.granted_index, tail: run_last,
                                          length: live_op.run_length});
                    if (int'(live_op.run_length) > longest_take)
                    begin
                        longest_take = int'(live_op.run_length);
                    end
                end
                send_gap = pick_gap();
            end
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0 || op_backlog.size() == 0)
                begin
                    if (send_gap > 0)
                    begin
                        send_gap--;
                    end
                    req.valid <= 1'b0;
                end
                else
                begin
                    live_op = op_backlog.pop_front();
                    req.valid        <= 1'b1;
                    req.func         <= live_op.func;
                    req.buffer_index <= live_op.buffer_index;
                    req.tail_index   <= live_op.tail_index;
                    req.run_length   <= live_op.run_length;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (grant_fifo.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected response beat: granted %0d status %0d free %0d",
                                 rsp.granted_index, rsp.status, rsp.free_left);
                    end
                    errors++;
                end
                else
                begin
                    want = grant_fifo.pop_front();
                    st_hits[int'(want.status)]++;
                    if (rsp.granted_index !== want.granted_index ||
                        rsp.status !== want.status || rsp.free_left !== want.free_left)
                    begin
                        if (errors < 10)
                        begin
                            $display("beat %0d: expected granted %0d status %0d free %0d, got %0d %0d %0d",
                                     beats_seen, want.granted_index, want.status, want.free_left,
                                     rsp.granted_index, rsp.status, rsp.free_left);
                        end
                        errors++;
                    end
                end
                beats_seen++;
                recv_gap = pick_gap();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (hold_taken != hold_asks)
            begin
                hold_taken++;
                hold_left = 250;
                rsp.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int issued;
        int burst;
        bit paused;
        req.valid        = 1'b0;
        req.func         = FN_TAKE_ONE;
        req.buffer_index = '0;
        req.tail_index   = '0;
        req.run_length   = '0;
        rsp.ready        = 1'b0;
        rst_n            = 1'b0;
        errors = 0;
        beats_seen = 0;
        sent_cnt = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        hold_asks = 0;
        hold_taken = 0;
        longest_take = 0;
        st_hits = '{0, 0, 0};
        steady = 1'b0;
        paused = 1'b0;
        issued = 0;
        pool_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // refusals on a full pool
        op_backlog.push_back(make_op(FN_RET_ONE, 0, 0, 0));
        op_backlog.push_back(make_op(FN_RET_RUN, 0, 0, 1));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 255, 255, 0));
        op_backlog.push_back(make_op(FN_RET_RUN, 255, 255, 0));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 511));
        // whole pool out, then empty pool
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 256));
        op_backlog.push_back(make_op(FN_TAKE_ONE, 255, 255, 511));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 1));
        // short chain: count says five, chain holds two
        op_backlog.push_back(make_op(FN_RET_RUN, 1, 0, 5));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 5));
        // null head while buffers remain counted
        op_backlog.push_back(make_op(FN_RET_RUN, 1, 0, 5));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 2));
        op_backlog.push_back(make_op(FN_TAKE_ONE, 0, 0, 0));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 1));
        op_backlog.push_back(make_op(FN_RET_RUN, 255, 0, 253));
        // single takes and give-backs, an oversized return, a run of three taken and given back
        op_backlog.push_back(make_op(FN_TAKE_ONE, 0, 0, 0));
        op_backlog.push_back(make_op(FN_TAKE_ONE, 0, 0, 0));
        op_backlog.push_back(make_op(FN_RET_ONE, 255, 0, 0));
        op_backlog.push_back(make_op(FN_RET_RUN, 254, 254, 300));
        op_backlog.push_back(make_op(FN_RET_RUN, 254, 254, 1));
        op_backlog.push_back(make_op(FN_TAKE_RUN, 0, 0, 3));
        op_backlog.push_back(make_op(FN_RET_RUN, 254, 253, 3));
        issued = op_backlog.size();
        wait_drained();

        while (issued < 1022)
        begin
            steady = ($urandom_range(0, 99) < 15);
            burst = $urandom_range(1, 12);
            if ((issued >= 300 && hold_asks == 0) || (issued >= 700 && hold_asks == 1))
            begin
                hold_asks++;
                steady = 1'b1;
                burst = 24;
            end
            if (issued >= 550 && !paused)
            begin
                wait_drained();
                paused = 1'b1;
            end
            repeat (burst)
            begin
                op_backlog.push_back(next_random_op());
                issued++;
            end
            wait_accepted();
        end

        wait_drained();
        repeat (600) @(negedge clk);
        $display("covered %0d requests: %0d done, %0d refused short, %0d refused bad",
                 sent_cnt, st_hits[0], st_hits[1], st_hits[2]);
        $display("longest run taken %0d, %0d long response stalls, %0d mismatches",
                 longest_take, hold_taken, errors);
        if (errors == 0 && grant_fifo.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d responses outstanding", grant_fifo.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
